@@ sv/gde_pkg.sv @@
// types and constants shared by the grouped dictionary encoder
package gde_pkg;

	localparam int VALUE_W  = 32;
	localparam int DICT_W   = 6;
	localparam int STATUS_W = 2;

	localparam logic ACT_LATCH  = 1'b0;
	localparam logic ACT_ENCODE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_LOAD,
		CS_SCAN,
		CS_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic               action;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [DICT_W-1:0] dict_position;
		status_e_t         status;
	} result_t;

	typedef struct packed {
		logic      clear;
		logic      latch;
		logic      load_grp;
		logic      load_fill;
		logic      scan;
		logic      append;
		logic      set_res;
		status_e_t res_status;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic hit;
		logic scan_done;
		logic full;
		logic out_free;
	} sts_t;

endpackage

@@ sv/grouped_dictionary_encoder_top.sv @@
// grouped dictionary encoder: a latch beat only loads the pending key; an encode
// beat loads the group's fill count, then scans its fill keys one key a cycle,
// fill being the group's key count, since the key memory has one read port.
// an out-of-range group key skips the memories and the scan; the next beat is
// taken in the cycle after the result register is loaded.
// after reset the fill-count memory is cleared one group a cycle, item_ready low
module grouped_dictionary_encoder_top #(
	parameter int GROUPS            = 1024,
	parameter int ENTRIES_PER_GROUP = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  gde_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output gde_pkg::result_t result
);
	import gde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gde_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_action (item.action),
		.item_ready  (item_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	gde_dpath #(
		.GROUPS            (GROUPS),
		.ENTRIES_PER_GROUP (ENTRIES_PER_GROUP)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_no_append_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !sts.full)
		else $error("append into a full group");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result register overwritten");

	a_zero_pos_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_FULL || result.status == ST_RANGE))
		|-> result.dict_position == '0)
		else $error("nonzero position on fault status");

	a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear || cmd.scan || cmd.load_fill) |-> !item_ready)
		else $error("beat offered while busy");

endmodule

@@ sv/gde_ctrl.sv @@
// controller state machine for the grouped dictionary encoder
module gde_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_action,
	output logic          item_ready,
	input  gde_pkg::sts_t sts,
	output gde_pkg::cmd_t cmd
);
	import gde_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		item_ready     = 1'b0;
		cmd            = '0;
		cmd.res_status = ST_FOUND;
		unique case (state_q)
			CS_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = CS_IDLE;
				end
			end
			CS_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == ACT_LATCH) begin
						cmd.latch = 1'b1;
					end else if (!sts.in_range) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_RANGE;
						state_d        = CS_EMIT;
					end else begin
						cmd.load_grp = 1'b1;
						state_d      = CS_LOAD;
					end
				end
			end
			CS_LOAD: begin
				cmd.load_fill = 1'b1;
				state_d       = CS_SCAN;
			end
			CS_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_FOUND;
					state_d        = CS_EMIT;
				end else if (sts.scan_done) begin
					cmd.set_res = 1'b1;
					if (sts.full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.append     = 1'b1;
						cmd.res_status = ST_ADDED;
					end
					state_d = CS_EMIT;
				end
			end
			CS_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			default: state_d = CS_CLEAR;
		endcase
	end

endmodule

@@ sv/gde_dpath.sv @@
// datapath: pending key, fill-count and key memories, scan counter, result register
module gde_dpath #(
	parameter int GROUPS            = 1024,
	parameter int ENTRIES_PER_GROUP = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gde_pkg::item_t   item,
	input  gde_pkg::cmd_t    cmd,
	output gde_pkg::sts_t    sts,
	output logic             result_valid,
	input  logic             result_ready,
	output gde_pkg::result_t result
);
	import gde_pkg::*;

	localparam int DEPTH = GROUPS * ENTRIES_PER_GROUP;
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int FW    = $clog2(ENTRIES_PER_GROUP + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = AW + FW;

	logic [VALUE_W-1:0] pend_q;
	logic [GW-1:0]      grp_q;
	logic [GW-1:0]      grp_in;
	logic [GW-1:0]      clr_idx_q;
	logic [FW-1:0]      fill_mem [GROUPS];
	logic [FW-1:0]      fill_rd_q;
	logic [FW-1:0]      fill_q;
	logic [VALUE_W-1:0] ent_mem [DEPTH];
	logic [VALUE_W-1:0] ent_rd_q;
	logic [AW-1:0]      base_q;
	logic [SW-1:0]      base_prod;
	logic [SW-1:0]      rd_sum;
	logic [SW-1:0]      wr_sum;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [FW-1:0]      rd_idx_q;
	logic [FW-1:0]      cmp_idx_q;
	logic               cmp_vld_q;
	logic               rd_more;
	logic [FW-1:0]      res_idx;
	logic [FW+DICT_W-1:0] res_ext;
	result_t            res_q;
	logic [VALUE_W-1:0] grp_m1;

	assign grp_m1  = item.value - VALUE_W'(1);
	assign grp_in  = grp_m1[GW-1:0];

	assign base_prod = SW'(grp_q) * SW'(ENTRIES_PER_GROUP);
	assign rd_sum    = SW'(base_q) + SW'(rd_idx_q);
	assign wr_sum    = SW'(base_q) + SW'(fill_q);
	assign rd_addr   = rd_sum[AW-1:0];
	assign wr_addr   = wr_sum[AW-1:0];
	assign rd_more   = rd_idx_q < fill_q;

	assign sts.in_range  = (item.value != '0) && (item.value <= VALUE_W'(GROUPS));
	assign sts.clr_last  = clr_idx_q == GW'(GROUPS - 1);
	assign sts.hit       = cmp_vld_q && (ent_rd_q == pend_q);
	assign sts.scan_done = !cmp_vld_q && !rd_more;
	assign sts.full      = fill_q >= FW'(ENTRIES_PER_GROUP);
	assign sts.out_free  = !result_valid || result_ready;

	// pending key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd.latch) begin
			pend_q <= item.value;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			clr_idx_q <= clr_idx_q + GW'(1);
		end
	end

	// fill-count memory
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			fill_mem[clr_idx_q] <= '0;
		end else if (cmd.append) begin
			fill_mem[grp_q] <= fill_q + FW'(1);
		end
		fill_rd_q <= fill_mem[grp_in];
	end

	// key memory
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			ent_mem[wr_addr] <= pend_q;
		end
		ent_rd_q <= ent_mem[rd_addr];
	end

	// group setup and scan
	always_ff @(posedge clk) begin
		if (cmd.load_grp) begin
			grp_q <= grp_in;
		end
		if (cmd.load_fill) begin
			fill_q    <= fill_rd_q;
			base_q    <= base_prod[AW-1:0];
			rd_idx_q  <= '0;
			cmp_idx_q <= '0;
		end else if (cmd.scan) begin
			cmp_idx_q <= rd_idx_q;
			if (rd_more) begin
				rd_idx_q <= rd_idx_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_q <= 1'b0;
		end else if (cmd.load_fill) begin
			cmp_vld_q <= 1'b0;
		end else if (cmd.scan) begin
			cmp_vld_q <= rd_more;
		end
	end

	// result selection
	always_comb begin
		case (cmd.res_status)
			ST_FOUND: res_idx = cmp_idx_q;
			ST_ADDED: res_idx = fill_q;
			default:  res_idx = '0;
		endcase
		res_ext = {{DICT_W{1'b0}}, res_idx};
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_q.dict_position <= res_ext[DICT_W-1:0];
			res_q.status        <= cmd.res_status;
		end
		if (cmd.load_out) begin
			result <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

endmodule
